// ===== hw/rtl/min_tracking_stack_unit_defines.svh =====
// Assertion macros for the minimum tracking stack unit.
`ifndef MIN_TRACKING_STACK_UNIT_DEFINES_SVH
`define MIN_TRACKING_STACK_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication checked at every rising edge outside of reset.
`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min tracking stack assertion failed");

// Next-cycle implication checked at every rising edge outside of reset.
`define MTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min tracking stack assertion failed");

`else

`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/mts_pkg.sv =====
// Shared types and constants for the minimum tracking stack unit.
package mts_pkg;

    localparam int DEPTH  = 1024;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = 32;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] push_value;
    } mts_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_value;
        logic signed [DATA_W-1:0] min_value;
        logic                     is_empty;
        logic [1:0]               status;
    } mts_out_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } mts_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } mts_cmd_t;

    typedef struct packed {
        logic out_valid;
    } mts_sts_t;

endpackage

// ===== hw/rtl/min_tracking_stack_unit.sv =====
// Top level of the minimum tracking stack unit.
// A push/pop stack of 1024 signed 32-bit words that reports its minimum after
// every transaction. Each input transaction has an accept cycle and an execute
// cycle: in the accept cycle the top of the value store and the entry below the
// current minimum are read from their synchronous memories, and in the following
// cycle the counts, the stores and the result register are updated. The result
// register is loaded at the edge after the accept. A new input is accepted only
// while no operation is in flight, since the registered memory read must finish
// before the stack pointer moves, and only while the result register is empty or
// is drained in that same cycle. A push onto a full stack is dropped and reported
// as overflow; a pop from an empty stack reports underflow with zero data and
// zero minimum. No clearing pass runs after reset: the stores hold garbage until
// written, and only written entries ever reach a result.
`include "min_tracking_stack_unit_defines.svh"

module min_tracking_stack_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mts_pkg::mts_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mts_pkg::mts_out_t out_data
);
    import mts_pkg::*;

    mts_cmd_t cmd;
    mts_sts_t sts;

    // The controller sequences the accept and execute cycles of each transaction.
    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds both stores, their counts and the result register.
    mts_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Only one transaction is in flight, so the unit is busy right after an accept.
    `MTS_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // The result slot is free in the execute cycle, so no result is overwritten.
    `MTS_ASSERT_NXT(a_slot_free, clk, rst_n, in_valid && in_ready, !out_valid)

    // An underflow leaves an empty stack with zero data and zero minimum.
    `MTS_ASSERT_IMP(a_underflow_result, clk, rst_n,
        out_valid && (out_data.status == STATUS_UNDERFLOW),
        out_data.is_empty && (out_data.data_value == '0) && (out_data.min_value == '0))

    // An empty stack always reports a zero minimum.
    `MTS_ASSERT_IMP(a_empty_min_zero, clk, rst_n,
        out_valid && out_data.is_empty, out_data.min_value == '0)

endmodule

// ===== hw/rtl/mts_ctrl.sv =====
// Controller state machine for the minimum tracking stack unit.
module mts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    input  mts_pkg::mts_sts_t sts,
    output mts_pkg::mts_cmd_t cmd
);
    import mts_pkg::*;

    mts_state_t state_reg;
    mts_state_t state_next;

    // A new transaction is taken only when the result slot is free by the next edge.
    assign in_ready = (state_reg == S_IDLE) && (!sts.out_valid || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid && in_ready;
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/mts_datapath.sv =====
// Datapath of the minimum tracking stack unit: stores, counts and result register.
module mts_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  mts_pkg::mts_in_t  in_data,
    input  mts_pkg::mts_cmd_t cmd,
    output mts_pkg::mts_sts_t sts,
    input  logic              out_ready,
    output logic              out_valid,
    output mts_pkg::mts_out_t out_data
);
    import mts_pkg::*;

    logic [DATA_W-1:0] value_mem [DEPTH];
    logic [DATA_W-1:0] min_mem   [DEPTH];

    logic [CNT_W-1:0]         vcount_reg;
    logic [CNT_W-1:0]         vcount_next;
    logic [CNT_W-1:0]         mcount_reg;
    logic [CNT_W-1:0]         mcount_next;
    logic signed [DATA_W-1:0] min_top_reg;
    logic signed [DATA_W-1:0] min_top_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    mts_out_t                 out_data_reg;
    mts_out_t                 out_data_next;

    logic                     op_func_reg;
    logic signed [DATA_W-1:0] op_value_reg;
    logic signed [DATA_W-1:0] val_rd_reg;
    logic signed [DATA_W-1:0] min_rd_reg;

    logic [CNT_W-1:0]  vcount_dec;
    logic [CNT_W-1:0]  mcount_dec2;
    logic [ADDR_W-1:0] val_rd_addr;
    logic [ADDR_W-1:0] min_rd_addr;
    logic [ADDR_W-1:0] val_wr_addr;
    logic [ADDR_W-1:0] min_wr_addr;
    logic              val_we;
    logic              min_we;
    logic              stack_full;
    logic              stack_empty;
    logic              min_push;

    // The pop reads the top value and the entry under the current minimum at once.
    assign vcount_dec  = vcount_reg - CNT_W'(1);
    assign mcount_dec2 = mcount_reg - CNT_W'(2);
    assign val_rd_addr = vcount_dec[ADDR_W-1:0];
    assign min_rd_addr = mcount_dec2[ADDR_W-1:0];
    assign val_wr_addr = vcount_reg[ADDR_W-1:0];
    assign min_wr_addr = mcount_reg[ADDR_W-1:0];

    assign stack_full  = (vcount_reg == CNT_W'(DEPTH));
    assign stack_empty = (vcount_reg == '0);
    assign min_push    = (mcount_reg == '0) || (op_value_reg <= min_top_reg);

    always_comb
    begin
        vcount_next   = vcount_reg;
        mcount_next   = mcount_reg;
        min_top_next  = min_top_reg;
        val_we        = 1'b0;
        min_we        = 1'b0;
        out_data_next = out_data_reg;

        if (cmd.execute)
        begin
            out_data_next.data_value = '0;
            out_data_next.status     = STATUS_OK;
            if (op_func_reg == FUNC_POP)
            begin
                if (stack_empty)
                begin
                    out_data_next.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    vcount_next              = vcount_dec;
                    out_data_next.data_value = val_rd_reg;
                    if ((mcount_reg != '0) && (val_rd_reg == min_top_reg))
                    begin
                        mcount_next  = mcount_reg - CNT_W'(1);
                        min_top_next = min_rd_reg;
                    end
                end
            end
            else
            begin
                if (stack_full)
                begin
                    out_data_next.status = STATUS_OVERFLOW;
                end
                else
                begin
                    val_we                   = 1'b1;
                    vcount_next              = vcount_reg + CNT_W'(1);
                    out_data_next.data_value = op_value_reg;
                    if (min_push)
                    begin
                        min_we       = 1'b1;
                        mcount_next  = mcount_reg + CNT_W'(1);
                        min_top_next = op_value_reg;
                    end
                end
            end
            out_data_next.min_value = (mcount_next != '0) ? min_top_next : '0;
            out_data_next.is_empty  = (vcount_next == '0);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[val_wr_addr] <= op_value_reg;
        end
        if (min_we)
        begin
            min_mem[min_wr_addr] <= op_value_reg;
        end
        if (cmd.capture)
        begin
            val_rd_reg <= value_mem[val_rd_addr];
            min_rd_reg <= min_mem[min_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_func_reg  <= in_data.func;
            op_value_reg <= in_data.push_value;
        end
        min_top_reg  <= min_top_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= '0;
            mcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vcount_reg    <= vcount_next;
            mcount_reg    <= mcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.out_valid = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the minimum tracking stack unit: directed and random push/pop traffic.
module tb_top;

    import mts_pkg::*;

    // The watchdog ends the run after this many cycles in a row with no transaction on
    // either channel. The slowest correct gap is the pipeline plus a random stall
    // whose chance of running that long is vanishingly small.
    localparam int STALL_LIMIT = 4000;

    // Random transactions sent in each of the three idling phases.
    localparam int RANDOM_PER_PHASE = 140;

    // Tracks the stack contents and the minima that the unit should hold. It works out
    // the expected result of each accepted input transaction and compares the results
    // that the unit returns, in order.
    class min_stack_tracker;
        logic signed [DATA_W-1:0] stack_values[$];
        logic signed [DATA_W-1:0] stack_minima[$];
        mts_out_t                 pending_results[$];
        int unsigned              mismatches;

        function new();
            mismatches = 0;
        endfunction

        task log_mismatch(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        // Applies one accepted push or pop and queues the result it must produce.
        function void apply_operation(input mts_in_t op);
            mts_out_t res;
            res = '0;
            res.status = STATUS_OK;
            if (op.func == FUNC_POP)
            begin
                if (stack_values.size() == 0)
                begin
                    res.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    res.data_value = stack_values.pop_back();
                    // A popped value that equals the minimum takes one copy of it off the
                    // minima, so duplicated minima unwind one at a time.
                    if (stack_minima.size() != 0 && res.data_value == stack_minima[$])
                        void'(stack_minima.pop_back());
                end
            end
            else
            begin
                if (stack_values.size() >= DEPTH)
                begin
                    res.status = STATUS_OVERFLOW;
                end
                else
                begin
                    if (stack_minima.size() == 0 ||
                        $signed(op.push_value) <= $signed(stack_minima[$]))
                        stack_minima.push_back(op.push_value);
                    stack_values.push_back(op.push_value);
                    res.data_value = op.push_value;
                end
            end
            res.min_value = (stack_minima.size() != 0) ? stack_minima[$] : '0;
            res.is_empty  = (stack_values.size() == 0);
            pending_results.push_back(res);
        endfunction

        // Compares one accepted result with the oldest expectation, field by field.
        task check_result(input mts_out_t got);
            mts_out_t want;
            if (pending_results.size() == 0)
            begin
                log_mismatch($sformatf("result %h arrived with nothing expected", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.data_value !== want.data_value)
                log_mismatch($sformatf("data_value %0d, expected %0d",
                                       got.data_value, want.data_value));
            if (got.min_value !== want.min_value)
                log_mismatch($sformatf("min_value %0d, expected %0d",
                                       got.min_value, want.min_value));
            if (got.is_empty !== want.is_empty)
                log_mismatch($sformatf("is_empty %b, expected %b",
                                       got.is_empty, want.is_empty));
            if (got.status !== want.status)
                log_mismatch($sformatf("status %0d, expected %0d",
                                       got.status, want.status));
        endtask
    endclass

    // Every input of the unit holds a known value from time zero.
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    mts_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    mts_out_t out_data;

    // Each channel's idle chance in percent. The stimulus sets them once per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;

    min_stack_tracker tracker = new();

    min_tracking_stack_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // Result side. The unit's outputs are sampled right after the rising edge, before
    // any nonblocking update of that edge lands, so they hold the values that the edge
    // itself saw. The ready for the next edge is then drawn from this phase's idle
    // chance.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(out_data);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: counts edges with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("min_tracking_stack_unit: mismatch");
                $finish;
            end
        end
    end

    // Offers one input transaction and holds it until the unit takes it. Random idle
    // cycles go in front of it. The call returns just after the accepting edge, and no
    // assignment has been made to the valid in that step yet, so the next call may
    // either drop it for a gap or keep it high for the next transaction.
    task automatic send_operation(input mts_in_t op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= op;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.apply_operation(op);
    endtask

    task automatic do_push(input logic signed [DATA_W-1:0] value);
        mts_in_t op;
        op.func       = FUNC_PUSH;
        op.push_value = value;
        send_operation(op);
    endtask

    // The value field of a pop carries random bits that the unit must ignore.
    task automatic do_pop();
        mts_in_t op;
        op.func       = FUNC_POP;
        op.push_value = $urandom;
        send_operation(op);
    endtask

    // Values are weighted toward a narrow band, so that repeats and ties with the
    // minimum are common, with full-range words and the extremes mixed in.
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] value;
        case ($urandom_range(9)) inside
            [0:3]: value = $urandom;
            [4:7]: value = $signed($urandom_range(20)) - 10;
            8:
            begin
                case ($urandom_range(3))
                    0:       value = 32'sh8000_0000;
                    1:       value = 32'sh7fff_ffff;
                    2:       value = '0;
                    default: value = -1;
                endcase
            end
            default:
            begin
                // Tie with the current minimum, when there is one.
                if (tracker.stack_minima.size() != 0)
                    value = tracker.stack_minima[$];
                else
                    value = $urandom;
            end
        endcase
        return value;
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the first idling profile.
        send_idle_pct = 12;
        recv_idle_pct = 76;

        // A pop on the empty stack after reset reports underflow.
        do_pop();
        // The first push always sets the minimum; a larger push after it leaves the minimum as it is.
        do_push(32'sd0);
        do_push(32'sh7fff_ffff);
        // The most negative word becomes the minimum, then ties with itself.
        do_push(32'sh8000_0000);
        do_push(32'sh8000_0000);
        do_push(-32'sd1);
        do_push(32'sd5);
        // Unwind: the duplicated minimum has to survive the first of its two pops.
        repeat (6) do_pop();
        // Back to empty, then underflow again.
        do_pop();
        do_pop();
        // Equal values on a small stack: 3, 3, 2, 3.
        do_push(32'sd3);
        do_push(32'sd3);
        do_push(32'sd2);
        do_push(32'sd3);
        repeat (4) do_pop();
        do_pop();

        // Random traffic in three phases: sender light and receiver heavy, then the
        // reverse, then no idling at all. Push and pop weights swap every 25
        // transactions, so the depth wanders up and down across the phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 76;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if ($urandom_range(99) < (((i / 25) % 2 == 0) ? 35 : 65))
                    do_pop();
                else
                    do_push(pick_value());
            end
        end

        in_valid <= 1'b0;

        // Wait for every expected result, then wait longer to catch any extra
        // result the unit might still send. The watchdog bounds the wait.
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("min_tracking_stack_unit: match");
        else
            $display("min_tracking_stack_unit: mismatch");
        $finish;
    end

endmodule
